// File: rtl/assert_macros.svh
// Assertion macros used by the converter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define MRC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("converter assertion failed");
`define MRC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("converter assertion failed");
`else
`define MRC_ASSERT(lbl, clk, rst, prop)
`define MRC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: rtl/mrc_pkg.sv
// Shared types and constants of the mixed-radix index converter.
package mrc_pkg;

  localparam int AXES       = 4;
  localparam int AXIS_BITS  = 12;
  localparam int FLAT_W     = 48;
  localparam int BINS_W     = 13;
  localparam int STRIDE_W   = 3 * BINS_W;
  localparam int PROD_W     = 4 * BINS_W;
  localparam int TOTAL_W    = 49;
  localparam int DIV_STAGES = FLAT_W;
  localparam int CFG_LAT    = 5;
  localparam int IDX_W      = 3;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_NUM_AXES    = 3'd0;
  localparam logic [IDX_W-1:0] REG_AXIS_BINS_0 = 3'd1;
  localparam logic [IDX_W-1:0] REG_AXIS_BINS_1 = 3'd2;
  localparam logic [IDX_W-1:0] REG_AXIS_BINS_2 = 3'd3;
  localparam logic [IDX_W-1:0] REG_AXIS_BINS_3 = 3'd4;

  localparam logic CMD_FLATTEN   = 1'b0;
  localparam logic CMD_UNFLATTEN = 1'b1;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic                 command;
    logic [AXIS_BITS-1:0] in_index_0;
    logic [AXIS_BITS-1:0] in_index_1;
    logic [AXIS_BITS-1:0] in_index_2;
    logic [AXIS_BITS-1:0] in_index_3;
    logic [FLAT_W-1:0]    in_flat;
  } in_t;

  typedef struct packed {
    logic [FLAT_W-1:0]    out_flat;
    logic [AXIS_BITS-1:0] out_index_0;
    logic [AXIS_BITS-1:0] out_index_1;
    logic [AXIS_BITS-1:0] out_index_2;
    logic [AXIS_BITS-1:0] out_index_3;
    logic                 beyond_total;
  } out_t;

  // Derived configuration seen by the lanes and the merge stage.
  typedef struct packed {
    logic                                busy;
    logic [2:0]                          n;
    logic [AXES-1:0][BINS_W-1:0]         eb;
    logic [AXES-1:0][STRIDE_W-1:0]       stride;
    logic [TOTAL_W-1:0]                  total;
  } cfg_t;

  // Item tag that travels beside the lanes.
  typedef struct packed {
    logic              valid;
    logic              command;
    logic [FLAT_W-1:0] flat;
  } tag_t;

endpackage

// File: rtl/mixed_radix_index_converter_core.sv
// Top level of the mixed-radix index converter.
// Converts per-axis bin indices to a row-major flat index (command 0) and a flat
// index back to axis indices (command 1), one transfer per cycle sustained.
// On its way from input to output, each item passes through two parts: each axis
// lane runs a 48-stage pipelined divider of the flat index by its stride, and a
// two-stage merge forms the flat sum or the axis digits. A stall while a result
// is waiting holds the whole pipeline. After reset and after every configuration
// write the input stalls while the stride and total products are rebuilt.
`include "assert_macros.svh"
module mixed_radix_index_converter_core import mrc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [BINS_W-1:0] cfg_data
);

  cfg_t                 cfg;
  logic                 en;
  logic                 accept;
  tag_t                 tag [DIV_STAGES];
  logic [AXIS_BITS-1:0] x_in [AXES];
  logic [FLAT_W-1:0]    q [AXES];
  logic [AXIS_BITS-1:0] x_out [AXES];

  mrc_cfg u_cfg (
    .clk, .rst, .cfg_valid, .cfg_index, .cfg_data, .cfg_ready, .cfg
  );

  // Pipeline advances unless a finished result is held by the output stall.
  assign en       = !(out_valid && out_stall);
  assign in_stall = cfg.busy || !en;
  assign accept   = in_valid && !in_stall;

  // Item tag line beside the divider lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STAGES; k++) tag[k].valid <= 1'b0;
    end else if (en) begin
      tag[0].valid   <= accept;
      tag[0].command <= in_data.command;
      tag[0].flat    <= in_data.in_flat;
      for (int k = 1; k < DIV_STAGES; k++) tag[k] <= tag[k-1];
    end
  end

  assign x_in[0] = in_data.in_index_0;
  assign x_in[1] = in_data.in_index_1;
  assign x_in[2] = in_data.in_index_2;
  assign x_in[3] = in_data.in_index_3;

  // One divider lane per axis.
  for (genvar i = 0; i < AXES; i++) begin : g_lane
    mrc_lane u_lane (
      .clk, .en,
      .flat   (in_data.in_flat),
      .x_in   (x_in[i]),
      .stride (cfg.stride[i]),
      .q      (q[i]),
      .x_out  (x_out[i])
    );
  end

  mrc_merge u_merge (
    .clk, .rst, .en,
    .tag (tag[DIV_STAGES-1]),
    .q, .x (x_out), .cfg,
    .out_valid, .out_data
  );

  `MRC_ASSERT(a_oor_clears_index, clk, rst,
    out_valid && out_data.beyond_total |-> out_data.out_index_0 == '0 &&
    out_data.out_index_1 == '0 && out_data.out_index_2 == '0 && out_data.out_index_3 == '0)
  `MRC_ASSERT(a_oor_no_flat, clk, rst,
    out_valid && out_data.beyond_total |-> out_data.out_flat == '0)
  `MRC_ASSERT(a_cfg_write_busy, clk, rst, cfg_valid && cfg_ready |=> in_stall)
  `MRC_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid && in_stall)

endmodule

// File: rtl/mrc_cfg.sv
// Configuration registers, stride and total bin count computation.
module mrc_cfg import mrc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [BINS_W-1:0] cfg_data,
  output logic              cfg_ready,
  output cfg_t              cfg
);

  logic [2:0]        num_axes;
  logic [BINS_W-1:0] axis_bins [AXES];
  logic [2:0]        n_use;
  logic [BINS_W-1:0] eb_comb [AXES];
  logic [BINS_W-1:0] eb [AXES];
  logic [2:0]        n;
  logic [2*BINS_W-1:0] p23;
  logic [STRIDE_W-1:0] p123;
  logic [PROD_W-1:0]   prod;
  logic [TOTAL_W-1:0]  total;
  logic [2:0]          busy_cnt;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_axes <= 3'd1;
      for (int i = 0; i < AXES; i++) axis_bins[i] <= BINS_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NUM_AXES:    num_axes     <= cfg_data[2:0];
        REG_AXIS_BINS_0: axis_bins[0] <= cfg_data;
        REG_AXIS_BINS_1: axis_bins[1] <= cfg_data;
        REG_AXIS_BINS_2: axis_bins[2] <= cfg_data;
        REG_AXIS_BINS_3: axis_bins[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective axis count and bin counts; unused axes and zero bin counts count as one bin.
  always_comb begin
    if (num_axes == 3'd0) n_use = 3'd1;
    else if (num_axes > 3'(AXES)) n_use = 3'(AXES);
    else n_use = num_axes;
    for (int j = 0; j < AXES; j++) begin
      if (3'(j) < n_use && axis_bins[j] != '0) eb_comb[j] = axis_bins[j];
      else eb_comb[j] = BINS_W'(1);
    end
  end

  // Product chain: bin counts registered, one multiplier per product stage, then the saturated total.
  always_ff @(posedge clk) begin
    n    <= n_use;
    eb   <= eb_comb;
    p23  <= (2*BINS_W)'(eb[2]) * (2*BINS_W)'(eb[3]);
    p123 <= STRIDE_W'(eb[1]) * STRIDE_W'(p23);
    prod <= PROD_W'(eb[0]) * PROD_W'(p123);
    total <= (prod > PROD_W'(TOTAL_MAX)) ? TOTAL_MAX : prod[TOTAL_W-1:0];
  end

  // Hold off items until the product chain has settled.
  always_ff @(posedge clk) begin
    if (rst || cfg_valid) busy_cnt <= 3'(CFG_LAT);
    else if (busy_cnt != 3'd0) busy_cnt <= busy_cnt - 3'd1;
  end

  always_comb begin
    cfg.busy      = (busy_cnt != 3'd0);
    cfg.n         = n;
    cfg.total     = total;
    for (int j = 0; j < AXES; j++) cfg.eb[j] = eb[j];
    cfg.stride[3] = STRIDE_W'(1);
    cfg.stride[2] = STRIDE_W'(eb[3]);
    cfg.stride[1] = STRIDE_W'(p23);
    cfg.stride[0] = p123;
  end

endmodule

// File: rtl/mrc_lane.sv
// One lane: pipelined restoring divider of the flat index by the axis stride.
module mrc_lane import mrc_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FLAT_W-1:0]    flat,
  input  logic [AXIS_BITS-1:0] x_in,
  input  logic [STRIDE_W-1:0]  stride,
  output logic [FLAT_W-1:0]    q,
  output logic [AXIS_BITS-1:0] x_out
);

  typedef struct packed {
    logic [STRIDE_W-1:0] rem;
    logic [FLAT_W-1:0]   sh;
  } div_t;

  div_t                 st [DIV_STAGES];
  logic [AXIS_BITS-1:0] xd [DIV_STAGES];
  div_t                 st_in;

  // One quotient bit: dividend bits shift out at the top, quotient bits in at the bottom.
  function automatic div_t div_step(div_t a, logic [STRIDE_W-1:0] d);
    logic [STRIDE_W:0] t;
    logic              ge;
    div_t              r;
    t  = {a.rem, a.sh[FLAT_W-1]};
    ge = (t >= {1'b0, d});
    if (ge) r.rem = STRIDE_W'(t - {1'b0, d});
    else r.rem = t[STRIDE_W-1:0];
    r.sh = {a.sh[FLAT_W-2:0], ge};
    return r;
  endfunction

  assign st_in = '{rem: '0, sh: flat};

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= div_step(st_in, stride);
      xd[0] <= x_in;
      for (int k = 1; k < DIV_STAGES; k++) begin
        st[k] <= div_step(st[k-1], stride);
        xd[k] <= xd[k-1];
      end
    end
  end

  assign q     = st[DIV_STAGES-1].sh;
  assign x_out = xd[DIV_STAGES-1];

endmodule

// File: rtl/mrc_merge.sv
// Merge stage: combines lane quotients into axis indices, or axis indices into a flat index.
module mrc_merge import mrc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  tag_t                 tag,
  input  logic [FLAT_W-1:0]    q [AXES],
  input  logic [AXIS_BITS-1:0] x [AXES],
  input  cfg_t                 cfg,
  output logic                 out_valid,
  output out_t                 out_data
);

  logic                 v1;
  logic                 cmd1;
  logic                 oor1;
  logic [FLAT_W-1:0]    fprod [AXES];
  logic [AXIS_BITS-1:0] qlow [AXES];
  logic [AXIS_BITS-1:0] mlow [AXES];
  logic [FLAT_W-1:0]    sum;
  logic [AXIS_BITS-1:0] digit [AXES];
  out_t                 res;

  // First stage: flatten terms, and the high-digit multiples for the remainders.
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= tag.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1 <= tag.command;
      oor1 <= (cfg.n != 3'd1) && ({1'b0, tag.flat} >= cfg.total);
      for (int i = 0; i < AXES; i++) begin
        if (3'(i) < cfg.n)
          fprod[i] <= FLAT_W'((FLAT_W + 3)'(x[i]) * (FLAT_W + 3)'(cfg.stride[i]));
        else
          fprod[i] <= '0;
        qlow[i] <= q[i][AXIS_BITS-1:0];
      end
      mlow[0] <= '0;
      for (int i = 1; i < AXES; i++)
        mlow[i] <= AXIS_BITS'(cfg.eb[i][AXIS_BITS-1:0] * q[i-1][AXIS_BITS-1:0]);
    end
  end

  // Axis digit is the lane quotient minus its bin count times the next higher quotient.
  always_comb begin
    sum = '0;
    for (int i = 0; i < AXES; i++) begin
      sum      = sum + fprod[i];
      digit[i] = qlow[i] - mlow[i];
    end
    res = '0;
    if (cmd1 == CMD_FLATTEN) begin
      res.out_flat = sum;
    end else if (oor1) begin
      res.beyond_total = 1'b1;
    end else begin
      res.out_index_0 = digit[0];
      res.out_index_1 = digit[1];
      res.out_index_2 = digit[2];
      res.out_index_3 = digit[3];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) out_data <= res;
  end

endmodule

// File: bench/mixed_radix_index_converter_core_tb.sv
// Self-checking testbench for the mixed-radix index converter core.
module mixed_radix_index_converter_core_tb;
  import mrc_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 93;
  localparam logic [63:0] FLAT_SPAN = 64'd1 << FLAT_W;
  localparam logic [IDX_W-1:0] REG_SPARE_5 = 3'd5;
  localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic [IDX_W-1:0] reg_idx;
    logic [BINS_W-1:0] reg_val;
    in_t              item;
    bit               typed;
    out_t             want;
  } row_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  in_t               in_data;
  logic              out_valid;
  logic              out_stall;
  out_t              out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index;
  logic [BINS_W-1:0] cfg_data;

  // Shadow copy of the configuration and the derived total bin count.
  logic [2:0]        axes_reg;
  logic [BINS_W-1:0] bins_reg [AXES];
  logic [63:0]       total_bins;

  out_t pending_results [$];
  row_t rows [$];
  int   mismatches;
  int   idle_cycles;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_req;

  mixed_radix_index_converter_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int axes_used();
    int n;
    n = axes_reg;
    if (n == 0) n = 1;
    if (n > AXES) n = AXES;
    return n;
  endfunction

  function automatic logic [63:0] eff_bins(int axis);
    return (bins_reg[axis] == '0) ? 64'd1 : 64'(bins_reg[axis]);
  endfunction

  // Product of the bin counts of the in-use axes after the given one.
  function automatic logic [63:0] stride(int axis, int n);
    logic [63:0] s;
    s = 64'd1;
    for (int j = axis + 1; j < n; j++) s = s * eff_bins(j);
    return s;
  endfunction

  // Register write as the block sees it, including the total recompute.
  function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [BINS_W-1:0] val);
    logic [63:0] t;
    if (idx == REG_NUM_AXES) axes_reg = val[2:0];
    else if (idx <= REG_AXIS_BINS_3) bins_reg[idx - REG_AXIS_BINS_0] = val;
    else return;
    t = 64'd1;
    for (int i = 0; i < axes_used(); i++) begin
      t = t * eff_bins(i);
      if (t > 64'(TOTAL_MAX)) t = 64'(TOTAL_MAX);
    end
    total_bins = t;
  endfunction

  // Expected conversion result for one input item.
  function automatic out_t convert(in_t d);
    out_t r;
    int n;
    logic [63:0] acc;
    logic [63:0] digit;
    logic [AXIS_BITS-1:0] ix [AXES];
    logic [AXIS_BITS-1:0] ox [AXES];
    r = '0;
    n = axes_used();
    ix = '{d.in_index_0, d.in_index_1, d.in_index_2, d.in_index_3};
    ox = '{default: '0};
    if (d.command == CMD_FLATTEN) begin
      acc = '0;
      for (int i = 0; i < n; i++) acc = acc + 64'(ix[i]) * stride(i, n);
      r.out_flat = acc[FLAT_W-1:0];
      return r;
    end
    if (n == 1) begin
      r.out_index_0 = d.in_flat[AXIS_BITS-1:0];
      return r;
    end
    if (64'(d.in_flat) >= total_bins) begin
      r.beyond_total = 1'b1;
      return r;
    end
    for (int i = 0; i < n; i++) begin
      digit = (64'(d.in_flat) / stride(i, n)) % eff_bins(i);
      ox[i] = digit[AXIS_BITS-1:0];
    end
    r.out_index_0 = ox[0];
    r.out_index_1 = ox[1];
    r.out_index_2 = ox[2];
    r.out_index_3 = ox[3];
    return r;
  endfunction

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 10);
    return $urandom_range(3, 1);
  endfunction

  // Random item: mostly in-range content for the current axes, some noise.
  function automatic in_t random_item();
    in_t d;
    logic [AXIS_BITS-1:0] ix [AXES];
    logic [63:0] span;
    int pick;
    d.command = 1'($urandom_range(1));
    for (int i = 0; i < AXES; i++) begin
      if ($urandom_range(7) == 0) ix[i] = AXIS_BITS'($urandom);
      else ix[i] = AXIS_BITS'($urandom_range(int'(eff_bins(i)) - 1));
    end
    d.in_index_0 = ix[0];
    d.in_index_1 = ix[1];
    d.in_index_2 = ix[2];
    d.in_index_3 = ix[3];
    span = (total_bins < FLAT_SPAN) ? total_bins : FLAT_SPAN;
    pick = $urandom_range(9);
    case (pick)
      0: d.in_flat = FLAT_W'({$urandom, $urandom});
      1: d.in_flat = FLAT_W'(span - 1);
      2: d.in_flat = FLAT_W'(total_bins);
      default: d.in_flat = FLAT_W'({$urandom, $urandom} % span);
    endcase
    return d;
  endfunction

  function automatic in_t mk_item(logic cmd, logic [AXIS_BITS-1:0] i0,
                                  logic [AXIS_BITS-1:0] i1, logic [AXIS_BITS-1:0] i2,
                                  logic [AXIS_BITS-1:0] i3, logic [FLAT_W-1:0] f);
    in_t d;
    d.command = cmd;
    d.in_index_0 = i0;
    d.in_index_1 = i1;
    d.in_index_2 = i2;
    d.in_index_3 = i3;
    d.in_flat = f;
    return d;
  endfunction

  function automatic void add_cfg(logic [IDX_W-1:0] idx, logic [BINS_W-1:0] val);
    row_t r;
    r = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, item: '0, typed: 1'b0, want: '0};
    rows.insert(rows.size(), r);
  endfunction

  function automatic void add_item(in_t d, bit typed, out_t want);
    row_t r;
    r = '{kind: ROW_ITEM, reg_idx: '0, reg_val: '0, item: d, typed: typed, want: want};
    rows.insert(rows.size(), r);
  endfunction

  function automatic out_t oor_result();
    out_t r;
    r = '0;
    r.beyond_total = 1'b1;
    return r;
  endfunction

  // Register writes happen only once every pending result has come back.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [BINS_W-1:0] val);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One input transfer; the expectation is queued once the block takes it.
  task automatic send_item(in_t d, bit typed, out_t want);
    int gap;
    gap = pick_gap(send_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (in_stall);
    pending_results.insert(pending_results.size(), typed ? want : convert(d));
  endtask

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        n = pick_gap(recv_idle_pct);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Result checker and progress watchdog.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, actual %p", want, out_data);
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus: directed table first, then randomly configured phases.
  initial begin
    out_t none;
    none = '0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    send_idle_pct = 30;
    recv_idle_pct = 30;
    axes_reg = 3'd1;
    bins_reg = '{default: BINS_W'(1)};
    total_bins = 64'd1;

    // Reset configuration: one axis, so indices pass straight through.
    add_item(mk_item(CMD_FLATTEN, '1, '1, '1, '1, '0), 1'b1, out_t'({48'hFFF, 49'b0}));
    add_item(mk_item(CMD_FLATTEN, '0, '0, '0, '0, '1), 1'b1, none);
    add_item(mk_item(CMD_UNFLATTEN, '0, '0, '0, '0, '1), 1'b1,
             out_t'({48'b0, 12'hFFF, 37'b0}));
    add_item(mk_item(CMD_UNFLATTEN, '1, '1, '1, '1, 48'h1234_5678_9ABC), 1'b1,
             out_t'({48'b0, 12'hABC, 37'b0}));
    // Four small axes, total of 210 bins.
    add_cfg(REG_NUM_AXES, 13'd4);
    add_cfg(REG_AXIS_BINS_0, 13'd5);
    add_cfg(REG_AXIS_BINS_1, 13'd7);
    add_cfg(REG_AXIS_BINS_2, 13'd3);
    add_cfg(REG_AXIS_BINS_3, 13'd2);
    add_item(mk_item(CMD_FLATTEN, 12'd4, 12'd6, 12'd2, 12'd1, '0), 1'b0, none);
    add_item(mk_item(CMD_FLATTEN, '1, '1, '1, '1, '0), 1'b0, none);
    add_item(mk_item(CMD_UNFLATTEN, '0, '0, '0, '0, 48'd209), 1'b0, none);
    add_item(mk_item(CMD_UNFLATTEN, '0, '0, '0, '0, 48'd0), 1'b0, none);
    add_item(mk_item(CMD_UNFLATTEN, '0, '0, '0, '0, 48'd210), 1'b1, oor_result());
    add_item(mk_item(CMD_UNFLATTEN, '0, '0, '0, '0, '1), 1'b1, oor_result());
    // Writes to missing registers change nothing.
    add_cfg(REG_SPARE_5, '1);
    add_cfg(REG_SPARE_7, 13'd3);
    add_item(mk_item(CMD_UNFLATTEN, '0, '0, '0, '0, 48'd123), 1'b0, none);
    // An axis count of zero acts as one axis.
    add_cfg(REG_NUM_AXES, 13'd0);
    add_item(mk_item(CMD_UNFLATTEN, '0, '0, '0, '0, 48'hFFFF_FFFF_F5A5), 1'b0, none);
    add_item(mk_item(CMD_FLATTEN, 12'h5A5, '1, '1, '1, '0), 1'b0, none);
    // Axis count above four saturates, largest bin counts, total saturates.
    add_cfg(REG_NUM_AXES, 13'd7);
    add_cfg(REG_AXIS_BINS_0, '1);
    add_cfg(REG_AXIS_BINS_1, '1);
    add_cfg(REG_AXIS_BINS_2, '1);
    add_cfg(REG_AXIS_BINS_3, '1);
    add_item(mk_item(CMD_FLATTEN, '1, '1, '1, '1, '0), 1'b0, none);
    add_item(mk_item(CMD_UNFLATTEN, '0, '0, '0, '0, '1), 1'b0, none);
    add_item(mk_item(CMD_UNFLATTEN, '0, '0, '0, '0, 48'h0000_0001_0001), 1'b0, none);
    // A zero bin count acts as one.
    add_cfg(REG_AXIS_BINS_1, 13'd0);
    add_item(mk_item(CMD_FLATTEN, 12'd7, 12'd9, 12'd11, 12'd13, '0), 1'b0, none);
    add_item(mk_item(CMD_UNFLATTEN, '0, '0, '0, '0, 48'd67_092_481), 1'b0, none);
    // Two axes of 4096 bins each.
    add_cfg(REG_NUM_AXES, 13'd2);
    add_cfg(REG_AXIS_BINS_0, 13'd4096);
    add_cfg(REG_AXIS_BINS_1, 13'd4096);
    add_item(mk_item(CMD_UNFLATTEN, '0, '0, '0, '0, 48'hFF_FFFF), 1'b0, none);
    add_item(mk_item(CMD_UNFLATTEN, '0, '0, '0, '0, 48'h100_0000), 1'b1, oor_result());
    add_item(mk_item(CMD_FLATTEN, '1, '1, 12'h0, 12'h0, '0), 1'b0, none);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_item(rows[i].item, rows[i].typed, rows[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      in_valid <= 1'b0;
      send_idle_pct = (p % 3 == 1) ? 0 : 30;
      recv_idle_pct = (p % 3 == 2) ? 0 : 30;
      if (p == PHASES - 1) begin
        write_reg(REG_NUM_AXES, 13'd4);
        for (int a = 0; a < AXES; a++) write_reg(IDX_W'(REG_AXIS_BINS_0 + a), '1);
      end else begin
        write_reg(REG_NUM_AXES, BINS_W'(($urandom_range(9) == 0) ? $urandom_range(7)
                                                                 : $urandom_range(4, 1)));
        for (int a = 0; a < AXES; a++) begin
          case ($urandom_range(11))
            0: write_reg(IDX_W'(REG_AXIS_BINS_0 + a), 13'd0);
            1: write_reg(IDX_W'(REG_AXIS_BINS_0 + a), 13'd4096);
            2: write_reg(IDX_W'(REG_AXIS_BINS_0 + a), '1);
            default: write_reg(IDX_W'(REG_AXIS_BINS_0 + a), BINS_W'($urandom_range(16, 1)));
          endcase
        end
      end
      // Let the pipeline fill against a long receiver hold-off once.
      if (p == 3) begin
        send_idle_pct = 0;
        hold_req = 1'b1;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) send_item(random_item(), 1'b0, none);
    end
    in_valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/mrc_pkg.sv
rtl/mrc_cfg.sv
rtl/mrc_lane.sv
rtl/mrc_merge.sv
rtl/mixed_radix_index_converter_core.sv
bench/mixed_radix_index_converter_core_tb.sv
